### design/m3i_pkg.sv
`timescale 1ns / 1ps

package m3i_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int NELEM     = 9;

  // Exact widths of the intermediate quantities.
  localparam int PROD_W = 2 * WORD_BITS;
  localparam int COF_W  = 2 * WORD_BITS + 1;
  localparam int CMAG_W = 2 * WORD_BITS;
  localparam int PP_W   = 2 * WORD_BITS + 1;
  localparam int DET_W  = 3 * WORD_BITS + 1;
  localparam int DMAG_W = 3 * WORD_BITS;
  localparam int CSH    = 2 * FRAC_BITS + 1;
  localparam int NUM_W  = ((CMAG_W + CSH) > DMAG_W ? (CMAG_W + CSH) : DMAG_W) + 1;
  localparam int DEN_W  = DMAG_W + 1;
  localparam int HI_W   = NUM_W - WORD_BITS;

  localparam int FRONT_LAT = 8;

  // Cofactor i of the adjugate is a[x]*a[y] - a[u]*a[v], listed as {x, y, u, v}.
  localparam int COF_IDX [NELEM][4] = '{
    '{4, 8, 7, 5}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
    '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{3, 2, 0, 5},
    '{3, 7, 6, 4}, '{6, 1, 0, 7}, '{0, 4, 3, 1}
  };

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [PROD_W-1:0]    prod_t;
  typedef logic signed [COF_W-1:0]     cof_t;
  typedef logic signed [PP_W-1:0]      pp_t;
  typedef logic signed [DET_W-1:0]     det_t;
  typedef logic [CMAG_W-1:0]           cmag_t;
  typedef logic [DMAG_W-1:0]           dmag_t;
  typedef logic [NUM_W-1:0]            num_t;
  typedef logic [DEN_W-1:0]            den_t;

  typedef struct packed {
    logic vld;
    logic sing;
  } ctl_t;

endpackage

### design/matrix3_inverse.sv
`timescale 1ns / 1ps

// Inverse of one 3x3 signed Q16.16 matrix per request. A request is taken whenever start
// is high; busy never rises, so a new matrix may follow every clock. Each result passes
// through 8 front stages for cofactors, determinant and scaling, 32 divider stages and
// one output register, and is shown for one cycle with out_valid high; the receiver
// cannot stall, so results must be taken as they come. Nine divider lanes, one per
// inverse element, each resolve one quotient bit per stage. Elements are
// rounded to nearest with ties away from zero and saturate to the word range. A zero
// determinant raises out_singular and gives an all-zero matrix.
module matrix3_inverse (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic signed [31:0]    in_a00,
  input  logic signed [31:0]    in_a01,
  input  logic signed [31:0]    in_a02,
  input  logic signed [31:0]    in_a10,
  input  logic signed [31:0]    in_a11,
  input  logic signed [31:0]    in_a12,
  input  logic signed [31:0]    in_a20,
  input  logic signed [31:0]    in_a21,
  input  logic signed [31:0]    in_a22,
  output logic                  out_valid,
  output logic signed [31:0]    out_b00,
  output logic signed [31:0]    out_b01,
  output logic signed [31:0]    out_b02,
  output logic signed [31:0]    out_b10,
  output logic signed [31:0]    out_b11,
  output logic signed [31:0]    out_b12,
  output logic signed [31:0]    out_b20,
  output logic signed [31:0]    out_b21,
  output logic signed [31:0]    out_b22,
  output logic                  out_singular
);

  m3i_pkg::word_t a_in  [m3i_pkg::NELEM];
  m3i_pkg::ctl_t  fctl;
  m3i_pkg::num_t  num   [m3i_pkg::NELEM];
  m3i_pkg::den_t  den;
  logic           neg   [m3i_pkg::NELEM];
  m3i_pkg::word_t res   [m3i_pkg::NELEM];

  m3i_pkg::ctl_t  ctl_r [m3i_pkg::WORD_BITS];
  logic           out_valid_r;
  logic           out_singular_r;
  m3i_pkg::word_t b_r   [m3i_pkg::NELEM];

  assign busy = 1'b0;

  assign a_in[0] = in_a00;
  assign a_in[1] = in_a01;
  assign a_in[2] = in_a02;
  assign a_in[3] = in_a10;
  assign a_in[4] = in_a11;
  assign a_in[5] = in_a12;
  assign a_in[6] = in_a20;
  assign a_in[7] = in_a21;
  assign a_in[8] = in_a22;

  m3i_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (start && !busy),
    .a_i    (a_in),
    .ctl_o  (fctl),
    .num_o  (num),
    .den_o  (den),
    .neg_o  (neg)
  );

  for (genvar i = 0; i < m3i_pkg::NELEM; i++) begin : g_lane
    m3i_lane u_lane (
      .clk   (clk),
      .num_i (num[i]),
      .den_i (den),
      .neg_i (neg[i]),
      .res_o (res[i])
    );
  end

  // Request flags ride alongside the divider lanes so they meet their quotients.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < m3i_pkg::WORD_BITS; s++) begin
        ctl_r[s] <= '0;
      end
      out_valid_r    <= 1'b0;
      out_singular_r <= 1'b0;
    end else begin
      ctl_r[0] <= fctl;
      for (int s = 1; s < m3i_pkg::WORD_BITS; s++) begin
        ctl_r[s] <= ctl_r[s-1];
      end
      out_valid_r    <= ctl_r[m3i_pkg::WORD_BITS-1].vld;
      out_singular_r <= ctl_r[m3i_pkg::WORD_BITS-1].vld && ctl_r[m3i_pkg::WORD_BITS-1].sing;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < m3i_pkg::NELEM; i++) begin
      b_r[i] <= ctl_r[m3i_pkg::WORD_BITS-1].sing ? '0 : res[i];
    end
  end

  assign out_valid    = out_valid_r;
  assign out_singular = out_singular_r;
  assign out_b00 = b_r[0];
  assign out_b01 = b_r[1];
  assign out_b02 = b_r[2];
  assign out_b10 = b_r[3];
  assign out_b11 = b_r[4];
  assign out_b12 = b_r[5];
  assign out_b20 = b_r[6];
  assign out_b21 = b_r[7];
  assign out_b22 = b_r[8];

  a_sing_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_singular |-> out_valid)
    else $error("singular flag raised without a result");

  a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_singular |-> out_b00 == '0 && out_b01 == '0 && out_b02 == '0 &&
                     out_b10 == '0 && out_b11 == '0 && out_b12 == '0 &&
                     out_b20 == '0 && out_b21 == '0 && out_b22 == '0)
    else $error("singular result is not all zero");

endmodule

### design/m3i_front.sv
`timescale 1ns / 1ps

module m3i_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_vld,
  input  m3i_pkg::word_t  a_i   [m3i_pkg::NELEM],
  output m3i_pkg::ctl_t   ctl_o,
  output m3i_pkg::num_t   num_o [m3i_pkg::NELEM],
  output m3i_pkg::den_t   den_o,
  output logic            neg_o [m3i_pkg::NELEM]
);

  logic [m3i_pkg::FRONT_LAT-1:0] vld_r;
  logic                          sing7_r;
  logic                          sing8_r;

  m3i_pkg::word_t a_r   [m3i_pkg::NELEM];
  m3i_pkg::word_t a2_r  [3];
  m3i_pkg::word_t a3_r  [3];
  m3i_pkg::prod_t px_r  [m3i_pkg::NELEM];
  m3i_pkg::prod_t pu_r  [m3i_pkg::NELEM];
  m3i_pkg::cof_t  cof3_r [m3i_pkg::NELEM];
  m3i_pkg::cof_t  cof4_r [m3i_pkg::NELEM];
  m3i_pkg::cof_t  cof5_r [m3i_pkg::NELEM];
  m3i_pkg::cof_t  cof6_r [m3i_pkg::NELEM];
  m3i_pkg::pp_t   pl_r  [3];
  m3i_pkg::pp_t   ph_r  [3];
  m3i_pkg::det_t  t_r   [3];
  m3i_pkg::det_t  det_r;
  m3i_pkg::dmag_t dmag_r;
  m3i_pkg::cmag_t cmag_r [m3i_pkg::NELEM];
  logic           neg7_r [m3i_pkg::NELEM];
  logic           neg8_r [m3i_pkg::NELEM];
  m3i_pkg::num_t  num_r [m3i_pkg::NELEM];
  m3i_pkg::den_t  den_r;

  m3i_pkg::det_t  det_abs;
  m3i_pkg::cof_t  cof_abs [m3i_pkg::NELEM];

  always_comb begin
    det_abs = det_r[m3i_pkg::DET_W-1] ? -det_r : det_r;
    for (int i = 0; i < m3i_pkg::NELEM; i++) begin
      cof_abs[i] = cof6_r[i][m3i_pkg::COF_W-1] ? -cof6_r[i] : cof6_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      sing7_r <= 1'b0;
      sing8_r <= 1'b0;
    end else begin
      vld_r   <= {vld_r[m3i_pkg::FRONT_LAT-2:0], in_vld};
      sing7_r <= (det_r == '0);
      sing8_r <= sing7_r;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_i;
    for (int i = 0; i < m3i_pkg::NELEM; i++) begin
      px_r[i]   <= a_r[m3i_pkg::COF_IDX[i][0]] * a_r[m3i_pkg::COF_IDX[i][1]];
      pu_r[i]   <= a_r[m3i_pkg::COF_IDX[i][2]] * a_r[m3i_pkg::COF_IDX[i][3]];
      cof3_r[i] <= m3i_pkg::cof_t'(px_r[i]) - m3i_pkg::cof_t'(pu_r[i]);
      cof4_r[i] <= cof3_r[i];
      cof5_r[i] <= cof4_r[i];
      cof6_r[i] <= cof5_r[i];
      cmag_r[i] <= cof_abs[i][m3i_pkg::CMAG_W-1:0];
      neg7_r[i] <= cof6_r[i][m3i_pkg::COF_W-1] ^ det_r[m3i_pkg::DET_W-1];
      neg8_r[i] <= neg7_r[i];
      num_r[i]  <= (m3i_pkg::num_t'(cmag_r[i]) << m3i_pkg::CSH) + m3i_pkg::num_t'(dmag_r);
    end
    // The determinant is expanded along the first row, each cofactor split in two halves
    // so that every product is of one word and a 33-bit half.
    for (int k = 0; k < 3; k++) begin
      a2_r[k] <= a_r[k];
      a3_r[k] <= a2_r[k];
      pl_r[k] <= a3_r[k] * $signed({1'b0, cof3_r[3*k][m3i_pkg::WORD_BITS-1:0]});
      ph_r[k] <= a3_r[k] * $signed(cof3_r[3*k][m3i_pkg::COF_W-1:m3i_pkg::WORD_BITS]);
      t_r[k]  <= (m3i_pkg::det_t'(ph_r[k]) <<< m3i_pkg::WORD_BITS)
                 + m3i_pkg::det_t'(pl_r[k]);
    end
    det_r  <= t_r[0] + t_r[1] + t_r[2];
    dmag_r <= det_abs[m3i_pkg::DMAG_W-1:0];
    den_r  <= m3i_pkg::den_t'(dmag_r) << 1;
  end

  assign ctl_o = '{vld: vld_r[m3i_pkg::FRONT_LAT-1], sing: sing8_r};
  assign num_o = num_r;
  assign den_o = den_r;
  assign neg_o = neg8_r;

  a_sing_den: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_o.vld |-> (ctl_o.sing == (den_o == '0)))
    else $error("singular flag disagrees with the denominator");

  a_num_round: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_o.vld && !ctl_o.sing |-> num_o[0] >= m3i_pkg::num_t'(den_o >> 1))
    else $error("numerator lost its rounding term");

endmodule

### design/m3i_lane.sv
`timescale 1ns / 1ps

module m3i_lane (
  input  logic           clk,
  input  m3i_pkg::num_t  num_i,
  input  m3i_pkg::den_t  den_i,
  input  logic           neg_i,
  output m3i_pkg::word_t res_o
);

  localparam int W = m3i_pkg::WORD_BITS;
  localparam int DW = m3i_pkg::DEN_W;

  logic [DW-1:0] rem_r [W];
  logic [DW-1:0] d_r   [W];
  logic [W-1:0]  nlo_r [W];
  logic [W-1:0]  q_r   [W];
  logic          ovf_r [W];
  logic          neg_r [W];

  // One quotient bit per stage, most significant first. The partial remainder stays
  // below the divisor unless the quotient already exceeds one word.
  for (genvar k = 0; k < W; k++) begin : g_stage
    logic [DW-1:0] rem_s;
    logic [DW-1:0] d_s;
    logic [W-1:0]  nlo_s;
    logic [W-1:0]  q_s;
    logic          ovf_s;
    logic          neg_s;
    logic [DW+1:0] trial;

    if (k == 0) begin : g_first
      always_comb begin
        rem_s = DW'(num_i[m3i_pkg::NUM_W-1:W]);
        d_s   = den_i;
        nlo_s = num_i[W-1:0];
        q_s   = '0;
        ovf_s = (rem_s >= den_i);
        neg_s = neg_i;
      end
    end else begin : g_next
      always_comb begin
        rem_s = rem_r[k-1];
        d_s   = d_r[k-1];
        nlo_s = nlo_r[k-1];
        q_s   = q_r[k-1];
        ovf_s = ovf_r[k-1];
        neg_s = neg_r[k-1];
      end
    end

    assign trial = {1'b0, rem_s, nlo_s[W-1]} - {2'b00, d_s};

    always_ff @(posedge clk) begin
      rem_r[k] <= trial[DW+1] ? {rem_s[DW-2:0], nlo_s[W-1]} : trial[DW-1:0];
      d_r[k]   <= d_s;
      nlo_r[k] <= nlo_s << 1;
      q_r[k]   <= {q_s[W-2:0], ~trial[DW+1]};
      ovf_r[k] <= ovf_s;
      neg_r[k] <= neg_s;
    end
  end

  logic [W-1:0] q_fin;
  logic [W-1:0] lim;

  always_comb begin
    q_fin = q_r[W-1];
    lim   = {1'b1, {(W-1){1'b0}}};
    if (neg_r[W-1]) begin
      res_o = (ovf_r[W-1] || q_fin > lim) ? lim : -q_fin;
    end else begin
      res_o = (ovf_r[W-1] || q_fin[W-1]) ? ~lim : q_fin;
    end
  end

  a_rem_bound: assert property (@(posedge clk)
    !ovf_r[W-1] && d_r[W-1] != '0 |-> rem_r[W-1] < d_r[W-1])
    else $error("partial remainder escaped the divisor bound");

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

  typedef logic signed [130:0] wide_t;

  typedef struct packed {
    logic [8:0][31:0] b;
    logic             sing;
  } inverse_t;

  logic           clk;
  logic           rst_n;
  logic           start;
  logic           busy;
  m3i_pkg::word_t in_a [9];
  logic           out_valid;
  m3i_pkg::word_t out_b [9];
  logic           out_singular;

  inverse_t expected_inv[$];
  int       n_errors;
  int       n_sent;
  int       n_checked;
  int       n_singular;

  localparam m3i_pkg::word_t ONE  = 32'sh0001_0000;
  localparam m3i_pkg::word_t WMAX = 32'sh7fff_ffff;
  localparam m3i_pkg::word_t WMIN = -32'sh7fff_ffff - 1;

  matrix3_inverse u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_a00(in_a[0]), .in_a01(in_a[1]), .in_a02(in_a[2]),
    .in_a10(in_a[3]), .in_a11(in_a[4]), .in_a12(in_a[5]),
    .in_a20(in_a[6]), .in_a21(in_a[7]), .in_a22(in_a[8]),
    .out_valid(out_valid),
    .out_b00(out_b[0]), .out_b01(out_b[1]), .out_b02(out_b[2]),
    .out_b10(out_b[3]), .out_b11(out_b[4]), .out_b12(out_b[5]),
    .out_b20(out_b[6]), .out_b21(out_b[7]), .out_b22(out_b[8]),
    .out_singular(out_singular)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Exact inverse: cofactors and determinant are formed wide enough that nothing is lost,
  // then each element is |cof| * 2^32 / |det| rounded half away from zero and saturated.
  function automatic inverse_t inverse_of(input m3i_pkg::word_t a [9]);
    int    idx [9][4];
    wide_t cof [9];
    wide_t det;
    wide_t cmag;
    wide_t dmag;
    wide_t q;
    logic  neg;
    inverse_t r;
    idx = '{'{4, 8, 7, 5}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
            '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{3, 2, 0, 5},
            '{3, 7, 6, 4}, '{6, 1, 0, 7}, '{0, 4, 3, 1}};
    for (int i = 0; i < 9; i++) begin
      cof[i] = wide_t'(a[idx[i][0]]) * wide_t'(a[idx[i][1]])
             - wide_t'(a[idx[i][2]]) * wide_t'(a[idx[i][3]]);
    end
    det = wide_t'(a[0]) * cof[0] + wide_t'(a[1]) * cof[3] + wide_t'(a[2]) * cof[6];
    r = '0;
    if (det == 0) begin
      r.sing = 1'b1;
      return r;
    end
    dmag = (det < 0) ? -det : det;
    for (int i = 0; i < 9; i++) begin
      cmag = (cof[i] < 0) ? -cof[i] : cof[i];
      neg  = (cof[i] < 0) ^ (det < 0);
      q = ((cmag <<< (2 * m3i_pkg::FRAC_BITS + 1)) + dmag) / (dmag <<< 1);
      if (neg) begin
        if (q > (wide_t'(1) <<< 31)) q = wide_t'(1) <<< 31;
        r.b[i] = -q[31:0];
      end else begin
        if (q > WMAX) q = WMAX;
        r.b[i] = q[31:0];
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    n_errors++;
    $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
  endtask

  always @(posedge clk) begin
    inverse_t want;
    if (rst_n && out_valid) begin
      if (expected_inv.size() == 0) begin
        n_errors++;
        $display("mismatch at %0t: result with no request outstanding", $realtime);
      end else begin
        want = expected_inv.pop_front();
        n_checked++;
        if (want.sing) n_singular++;
        if (out_singular !== want.sing)
          report_mismatch("singular", 32'(out_singular), 32'(want.sing));
        for (int i = 0; i < 9; i++) begin
          if (out_b[i] !== want.b[i])
            report_mismatch($sformatf("b%0d%0d", i / 3, i % 3), out_b[i], want.b[i]);
        end
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the request was taken,
  // with start still high so that a burst can carry straight on.
  task automatic send_matrix(input m3i_pkg::word_t m [9]);
    in_a  = m;
    start = 1'b1;
    do @(posedge clk); while (busy);
    expected_inv.push_back(inverse_of(m));
    n_sent++;
    @(negedge clk);
  endtask

  task automatic idle_for(input int n);
    start = 1'b0;
    for (int i = 0; i < n; i++) begin
      foreach (in_a[k]) in_a[k] = m3i_pkg::word_t'($urandom);
      @(negedge clk);
    end
  endtask

  task automatic gap_maybe();
    if ($urandom_range(0, 3) == 0) idle_for($urandom_range(1, 6));
  endtask

  function automatic m3i_pkg::word_t small_value();
    case ($urandom_range(0, 3))
      0: return m3i_pkg::word_t'($signed($urandom_range(0, 16)) - 8) <<< 16;
      1: return m3i_pkg::word_t'($signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000);
      2: return m3i_pkg::word_t'($signed($urandom_range(0, 400)) - 200);
      default: return m3i_pkg::word_t'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    m3i_pkg::word_t m [9];
    m = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE};
    send_matrix(m);
    m = '{default: 0};
    send_matrix(m);
    m = '{default: WMAX};
    send_matrix(m);
    m = '{default: WMIN};
    send_matrix(m);
    m = '{WMIN, 0, 0, 0, WMIN, 0, 0, 0, WMIN};
    send_matrix(m);
    m = '{WMAX, 0, 0, 0, WMAX, 0, 0, 0, WMAX};
    send_matrix(m);
    // Tiny diagonal: the inverse overflows and must saturate both ways.
    m = '{1, 0, 0, 0, -1, 0, 0, 0, 1};
    send_matrix(m);
    m = '{WMIN, WMAX, 0, WMAX, WMIN, 0, 0, 0, -1};
    send_matrix(m);
    // Diagonal of 3 gives a third, where rounding matters.
    m = '{3 * ONE, 0, 0, 0, 3 * ONE, 0, 0, 0, -3 * ONE};
    send_matrix(m);
    m = '{2 * ONE, 0, 0, 0, 2, 0, 0, 0, 4 * ONE};
    send_matrix(m);
    // Duplicated rows give a zero determinant.
    m = '{ONE, 2 * ONE, 3 * ONE, ONE, 2 * ONE, 3 * ONE, 7, WMIN, WMAX};
    send_matrix(m);
    m = '{0, ONE, 0, ONE, 0, 0, 0, 0, ONE};
    send_matrix(m);
    m = '{WMAX, WMIN, WMAX, WMIN, WMAX, WMIN, WMAX, WMIN, -1};
    send_matrix(m);
    m = '{-1, -1, 0, 1, -1, 0, 0, 0, 1};
    send_matrix(m);
    m = '{32'sh5555_5555, 32'shaaaa_aaaa, 0, 0, 32'sh5555_5555, 0, 1, 0, ONE};
    send_matrix(m);
    idle_for(3);
  endtask

  task automatic test_random(input int n_items, input int kind);
    m3i_pkg::word_t m [9];
    int    burst;
    int    done;
    done = 0;
    while (done < n_items) begin
      burst = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      for (int i = 0; i < burst && done < n_items; i++) begin
        foreach (m[k]) m[k] = (kind == 0) ? m3i_pkg::word_t'($urandom) : small_value();
        if (kind == 2) begin
          // Make the rows dependent so the determinant vanishes, unless doubling a large entry wraps.
          case ($urandom_range(0, 2))
            0: for (int k = 0; k < 3; k++) m[6 + k] = m[k];
            1: for (int k = 0; k < 3; k++) m[3 + k] = m[k] * 2;
            default: for (int k = 0; k < 3; k++) m[3 * k + 1] = 0;
          endcase
        end
        send_matrix(m);
        done++;
      end
      idle_for($urandom_range(1, 12));
    end
  endtask

  initial begin
    int wait_cycles;
    n_errors  = 0;
    n_sent    = 0;
    n_checked = 0;
    n_singular = 0;
    start = 1'b0;
    foreach (in_a[k]) in_a[k] = '0;
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_directed();
    test_random(500, 0);
    test_random(750, 1);
    test_random(150, 2);
    idle_for(1);
    wait_cycles = 0;
    while (expected_inv.size() != 0 && wait_cycles < 2000) begin
      @(negedge clk);
      wait_cycles++;
    end
    if (expected_inv.size() != 0) begin
      n_errors++;
      $display("%0d results never arrived", expected_inv.size());
    end
    repeat (60) @(negedge clk);
    $display("sent %0d matrices, checked %0d inverses, %0d of them singular",
             n_sent, n_checked, n_singular);
    $display("stimulus: extremes, saturation, full-range, small-range and dependent rows");
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout");
    $display("status: fail");
    $finish;
  end

endmodule
